@@ sv/hsfp_pkg.sv @@
// Shared types and constants for the five-point heat stencil.
// No dependencies; imported by every module of the block except hsfp_fifo.
package hsfp_pkg;

  localparam int unsigned CFG_COLS_W  = 11;
  localparam int unsigned CFG_ROWS_W  = 16;
  localparam int unsigned CFG_RATIO_W = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned ROW_CNT_W   = CFG_ROWS_W + 1;
  // fractional bits of the Q0.16 coefficient
  localparam int unsigned RATIO_FRAC  = 16;

  localparam logic [CFG_COLS_W-1:0]  COLS_RST  = 11'd1024;
  localparam logic [CFG_ROWS_W-1:0]  ROWS_RST  = 16'd1024;
  localparam logic [CFG_RATIO_W-1:0] RATIO_RST = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_INTERIOR_COLS   = 2'd0,
    IDX_INTERIOR_ROWS   = 2'd1,
    IDX_DIFFUSION_RATIO = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_COLS_W-1:0]  interior_cols;
    logic [CFG_ROWS_W-1:0]  interior_rows;
    logic [CFG_RATIO_W-1:0] diffusion_ratio;
  } hsfp_cfg_t;

  // per-sample classification made by the front end
  typedef struct packed {
    logic mid_en;   // row >= 1: middle line store holds valid data
    logic up_en;    // row >= 2: upper line store holds valid data
    logic produce;  // sample completes an interior stencil
    logic last;     // completes the last interior cell of the grid
  } hsfp_flags_t;

  localparam int unsigned FLAGS_W = $bits(hsfp_flags_t);

endpackage

@@ sv/hsfp_fifo.sv @@
// Small register-based FIFO used for the front/back queue and the result queue.
// No dependencies. DEPTH must be a power of two.
module hsfp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH):0]     count_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      count_r;
  logic             do_push, do_pop;

  assign full_o  = (count_r == (AW+1)'(DEPTH));
  assign empty_o = (count_r == '0);
  assign count_o = count_r;
  assign rdata_o = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + AW'(1);
      if (do_push && !do_pop)      count_r <= count_r + (AW+1)'(1);
      else if (do_pop && !do_push) count_r <= count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata_i;
  end

endmodule

@@ sv/hsfp_front.sv @@
// Front end: padded-grid column/row counters and per-sample classification.
// Depends on hsfp_pkg.
module hsfp_front #(
  parameter int unsigned MAX_COLS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hsfp_pkg::hsfp_cfg_t         cfg_i,
  input  logic                        accept_i,
  output logic [$clog2(MAX_COLS+2)-1:0] col_o,
  output hsfp_pkg::hsfp_flags_t       flags_o
);

  import hsfp_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_COLS + 2);
  localparam int unsigned PW_W  = (COL_W + 1 > CFG_COLS_W + 1) ? COL_W + 1 : CFG_COLS_W + 1;

  logic [PW_W-1:0]      col_r, col_nxt;
  logic [ROW_CNT_W-1:0] row_r, row_nxt;
  logic [PW_W-1:0]      cols_ext, cols_eff, pw, c_cur, c_inc;
  logic [CFG_ROWS_W-1:0] rows_eff;
  logic [ROW_CNT_W-1:0] ph, r_cur;
  logic [ROW_CNT_W:0]   r_tmp, r_inc;
  logic                 wrap;

  always_comb begin
    cols_ext = PW_W'(cfg_i.interior_cols);
    if (cols_ext == '0)                   cols_eff = PW_W'(1);
    else if (cols_ext > PW_W'(MAX_COLS))  cols_eff = PW_W'(MAX_COLS);
    else                                  cols_eff = cols_ext;
    pw = cols_eff + PW_W'(2);

    rows_eff = (cfg_i.interior_rows == '0) ? CFG_ROWS_W'(1) : cfg_i.interior_rows;
    ph = ROW_CNT_W'(rows_eff) + ROW_CNT_W'(2);

    // a count left past the padded width (after a geometry change) ends the row
    wrap  = (col_r >= pw);
    c_cur = wrap ? '0 : col_r;
    r_tmp = wrap ? (ROW_CNT_W+1)'(row_r) + (ROW_CNT_W+1)'(1) : (ROW_CNT_W+1)'(row_r);
    r_cur = (r_tmp >= (ROW_CNT_W+1)'(ph)) ? '0 : r_tmp[ROW_CNT_W-1:0];

    c_inc = c_cur + PW_W'(1);
    r_inc = (ROW_CNT_W+1)'(r_cur) + (ROW_CNT_W+1)'(1);
    if (c_inc >= pw) begin
      col_nxt = '0;
      row_nxt = (r_inc >= (ROW_CNT_W+1)'(ph)) ? '0 : r_inc[ROW_CNT_W-1:0];
    end else begin
      col_nxt = c_inc;
      row_nxt = r_cur;
    end

    col_o           = c_cur[COL_W-1:0];
    flags_o.mid_en  = (r_cur != '0);
    flags_o.up_en   = (r_cur >= ROW_CNT_W'(2));
    flags_o.produce = (r_cur >= ROW_CNT_W'(2)) && (c_cur >= PW_W'(2));
    flags_o.last    = (c_cur == pw - PW_W'(1)) && (r_cur == ph - ROW_CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept_i) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // the last-cell flag only ever rides on a result-producing sample
  a_last_produces: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_i && flags_o.last) |-> flags_o.produce)
    else $error("last flag on a sample that produces no result");

  // padded width is at least three, so the column always moves
  a_col_moves: assert property (@(posedge clk) disable iff (!rst_n)
    accept_i |=> (col_r != $past(col_r)))
    else $error("column counter stuck after a transaction");

endmodule

@@ sv/hsfp_back.sv @@
// Back end: two line stores, neighbour window and the stencil arithmetic pipeline.
// Depends on hsfp_pkg; feeds the result FIFO in the top level.
module hsfp_back #(
  parameter int unsigned MAX_COLS    = 1024,
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned OUT_DEPTH   = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [hsfp_pkg::CFG_RATIO_W-1:0]     ratio_i,
  input  logic                                 q_empty_i,
  input  logic signed [SAMPLE_BITS-1:0]        q_sample_i,
  input  logic [$clog2(MAX_COLS+2)-1:0]        q_col_i,
  input  hsfp_pkg::hsfp_flags_t                q_flags_i,
  output logic                                 q_pop_o,
  input  logic [$clog2(OUT_DEPTH):0]           out_count_i,
  output logic                                 out_push_o,
  output logic signed [SAMPLE_BITS-1:0]        out_temp_o,
  output logic                                 out_last_o
);

  import hsfp_pkg::*;

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned COL_W  = $clog2(MAX_COLS + 2);
  localparam int unsigned DEPTH  = MAX_COLS + 2;
  localparam int unsigned LAP_W  = SB + 3;
  localparam int unsigned PROD_W = LAP_W + CFG_RATIO_W;
  localparam int unsigned SUM_W  = LAP_W + 1;
  localparam int unsigned CNT_W  = $clog2(OUT_DEPTH) + 1;
  localparam logic signed [SB-1:0] SAT_HI = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAT_LO = {1'b1, {(SB-1){1'b0}}};

  // line stores, no reset: read data is used only for entries already written
  logic signed [SB-1:0] mid_mem [DEPTH];
  logic signed [SB-1:0] up_mem  [DEPTH];
  logic signed [SB-1:0] mid_rd_r, up_rd_r;

  logic                 s1_valid_r;
  hsfp_flags_t          s1_flags_r;
  logic [COL_W-1:0]     s1_col_r;
  logic signed [SB-1:0] s1_sample_r;
  logic signed [SB-1:0] mid_val, up_val;
  logic                 up_we;

  // window: middle row at c-1 and c-2, upper row at c-1, input row at c-1
  logic signed [SB-1:0] win_mid1_r, win_mid2_r, win_up1_r, win_in1_r;

  logic                    s2_valid_r, s2_last_r;
  logic signed [SB-1:0]    s2_centre_r;
  logic signed [LAP_W-1:0] s2_suma_r, s2_sumb_r;

  logic                    s3_valid_r, s3_last_r;
  logic signed [SB-1:0]    s3_centre_r;
  logic signed [LAP_W-1:0] s3_lap_r;

  logic                     s4_valid_r, s4_last_r;
  logic signed [SB-1:0]     s4_centre_r;
  logic signed [PROD_W-1:0] s4_prod_r;

  logic signed [LAP_W-1:0] q_w;
  logic signed [SUM_W-1:0] sum_w;
  logic [CNT_W:0]          credit;

  // reserve a result slot for every producing sample in flight
  always_comb begin
    credit = (CNT_W+1)'(out_count_i)
           + (CNT_W+1)'(s1_valid_r && s1_flags_r.produce)
           + (CNT_W+1)'(s2_valid_r) + (CNT_W+1)'(s3_valid_r) + (CNT_W+1)'(s4_valid_r);
    q_pop_o = !q_empty_i && (credit < (CNT_W+1)'(OUT_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) begin
      mid_rd_r         <= mid_mem[q_col_i];
      mid_mem[q_col_i] <= q_sample_i;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) up_rd_r <= up_mem[q_col_i];
    if (up_we)   up_mem[s1_col_r] <= mid_val;
  end

  assign mid_val = s1_flags_r.mid_en ? mid_rd_r : '0;
  assign up_val  = s1_flags_r.up_en  ? up_rd_r  : '0;
  assign up_we   = s1_valid_r && s1_flags_r.mid_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      win_mid1_r <= '0;
      win_mid2_r <= '0;
      win_up1_r  <= '0;
      win_in1_r  <= '0;
    end else begin
      s1_valid_r <= q_pop_o;
      s2_valid_r <= s1_valid_r && s1_flags_r.produce;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      if (s1_valid_r) begin
        win_mid2_r <= win_mid1_r;
        win_mid1_r <= mid_val;
        win_up1_r  <= up_val;
        win_in1_r  <= s1_sample_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_flags_r  <= q_flags_i;
    s1_col_r    <= q_col_i;
    s1_sample_r <= q_sample_i;

    // centre = mid(c-1); n = up(c-1); s = in(c-1); e = mid(c); w = mid(c-2)
    s2_last_r   <= s1_flags_r.last;
    s2_centre_r <= win_mid1_r;
    s2_suma_r   <= LAP_W'(win_up1_r) + LAP_W'(win_in1_r);
    s2_sumb_r   <= LAP_W'(mid_val) + LAP_W'(win_mid2_r);

    s3_last_r   <= s2_last_r;
    s3_centre_r <= s2_centre_r;
    s3_lap_r    <= s2_suma_r + s2_sumb_r - (LAP_W'(s2_centre_r) <<< 2);

    s4_last_r   <= s3_last_r;
    s4_centre_r <= s3_centre_r;
    s4_prod_r   <= $signed({1'b0, ratio_i}) * s3_lap_r;
  end

  // floor by arithmetic shift, add centre, clamp to the sample range
  always_comb begin
    q_w   = LAP_W'(s4_prod_r >>> RATIO_FRAC);
    sum_w = SUM_W'(s4_centre_r) + SUM_W'(q_w);
    if (sum_w > SUM_W'(SAT_HI))      out_temp_o = SAT_HI;
    else if (sum_w < SUM_W'(SAT_LO)) out_temp_o = SAT_LO;
    else                             out_temp_o = SB'(sum_w);
    out_push_o = s4_valid_r;
    out_last_o = s4_last_r;
  end

  a_no_out_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_push_o |-> (out_count_i < CNT_W'(OUT_DEPTH)))
    else $error("result pushed into a full result queue");

  // the upper-store write-back never collides with the read of the next sample
  a_up_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (up_we && q_pop_o) |-> (s1_col_r != q_col_i))
    else $error("upper line store read and written at the same column");

endmodule

@@ sv/heat_stencil_five_point.sv @@
// One explicit timestep of the 2D heat equation with a five-point stencil. The padded
// grid (interior plus a one-cell halo) is pushed in raster order, one signed Q16.16
// sample per transaction, (interior_cols+2) x (interior_rows+2) transactions per frame;
// frames follow each other with no gap. For every interior cell one result
// new = c + floor(r*(n+s+e+w-4c) / 2^16), saturated, is popped; halo cells give none,
// and frame_end marks the last interior cell. The block takes one sample per clock
// cycle and sustains that rate as long as results are popped; its pace is set by the
// single read port of each line store and the one multiplier, both used once per
// sample. After its south-east neighbour is pushed, a cell's result passes through the
// front queue, the line-store read, two add stages, the multiply and the result queue. A
// 4-entry queue separates the counters from the datapath and an 8-entry result queue
// absorbs stalls on the output. The line stores are two memories of MAX_COLS+2 words
// with no clearing pass: they are ready straight after reset. Write the registers
// (index 0 interior_cols, 1 interior_rows, 2 diffusion_ratio) only between frames.
// Top level; depends on hsfp_pkg, hsfp_fifo, hsfp_front and hsfp_back.
module heat_stencil_five_point #(
  parameter int unsigned MAX_COLS    = 1024,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  logic signed [SAMPLE_BITS-1:0]       in_old_temp,
  output logic                                in_full,
  input  logic                                out_pop,
  output logic                                out_empty,
  output logic signed [SAMPLE_BITS-1:0]       out_new_temp,
  output logic                                out_frame_end,
  input  logic                                cfg_we,
  input  logic [hsfp_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [hsfp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import hsfp_pkg::*;

  localparam int unsigned COL_W      = $clog2(MAX_COLS + 2);
  localparam int unsigned IN_Q_DEPTH = 4;
  localparam int unsigned OUT_DEPTH  = 8;
  localparam int unsigned IQ_W       = SAMPLE_BITS + COL_W + FLAGS_W;
  localparam int unsigned OQ_W       = SAMPLE_BITS + 1;

  hsfp_cfg_t cfg_r, cfg_nxt;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        IDX_INTERIOR_COLS:   cfg_nxt.interior_cols   = cfg_wdata[CFG_COLS_W-1:0];
        IDX_INTERIOR_ROWS:   cfg_nxt.interior_rows   = cfg_wdata[CFG_ROWS_W-1:0];
        IDX_DIFFUSION_RATIO: cfg_nxt.diffusion_ratio = cfg_wdata[CFG_RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interior_cols   <= COLS_RST;
      cfg_r.interior_rows   <= ROWS_RST;
      cfg_r.diffusion_ratio <= RATIO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end: counts position in the padded grid and tags each sample
  logic [COL_W-1:0] front_col;
  hsfp_flags_t      front_flags;
  logic             in_accept;

  assign in_accept = in_push && !in_full;

  hsfp_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg_r),
    .accept_i (in_accept),
    .col_o    (front_col),
    .flags_o  (front_flags)
  );

  // queue between front and back: sample, column, flags
  logic [IQ_W-1:0]        iq_rdata;
  logic                   iq_empty, iq_pop;
  logic signed [SAMPLE_BITS-1:0] iq_sample;
  logic [COL_W-1:0]       iq_col;
  hsfp_flags_t            iq_flags;

  hsfp_fifo #(
    .WIDTH (IQ_W),
    .DEPTH (IN_Q_DEPTH)
  ) u_in_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (in_push),
    .wdata_i ({in_old_temp, front_col, front_flags}),
    .full_o  (in_full),
    .pop_i   (iq_pop),
    .rdata_o (iq_rdata),
    .empty_o (iq_empty),
    .count_o ()
  );

  assign iq_sample = iq_rdata[IQ_W-1 -: SAMPLE_BITS];
  assign iq_col    = iq_rdata[COL_W+FLAGS_W-1 -: COL_W];
  assign iq_flags  = hsfp_flags_t'(iq_rdata[FLAGS_W-1:0]);

  // back end: line stores, window, arithmetic
  logic [$clog2(OUT_DEPTH):0]    oq_count;
  logic                          back_push, back_last;
  logic signed [SAMPLE_BITS-1:0] back_temp;
  logic [OQ_W-1:0]               oq_rdata;

  hsfp_back #(
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .OUT_DEPTH   (OUT_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .ratio_i     (cfg_r.diffusion_ratio),
    .q_empty_i   (iq_empty),
    .q_sample_i  (iq_sample),
    .q_col_i     (iq_col),
    .q_flags_i   (iq_flags),
    .q_pop_o     (iq_pop),
    .out_count_i (oq_count),
    .out_push_o  (back_push),
    .out_temp_o  (back_temp),
    .out_last_o  (back_last)
  );

  // result queue; the back end never pushes without a reserved slot
  hsfp_fifo #(
    .WIDTH (OQ_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (back_push),
    .wdata_i ({back_temp, back_last}),
    .full_o  (),
    .pop_i   (out_pop),
    .rdata_o (oq_rdata),
    .empty_o (out_empty),
    .count_o (oq_count)
  );

  assign out_new_temp  = oq_rdata[OQ_W-1:1];
  assign out_frame_end = oq_rdata[0];

endmodule

@@ dv/heat_stencil_five_point_tb.sv @@
// Self-checking testbench for heat_stencil_five_point, the five-point heat stencil.
// Whole padded frames are streamed in, results are predicted per accepted sample.
// Depends on hsfp_pkg and the heat_stencil_five_point RTL.
`timescale 1ns / 1ps

module heat_stencil_five_point_tb;
  import hsfp_pkg::*;

  localparam int unsigned MAX_COLS       = 1024;
  localparam int unsigned SAMPLE_BITS    = 32;
  // idle cycles let through after the last result before a register write or the verdict
  localparam int unsigned DRAIN_CYCLES   = 16;
  // cycles with no transaction on either side before the run is abandoned
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam longint      STENCIL_POINTS = 4;
  localparam longint      TEMP_MAX       = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint      TEMP_MIN       = -(longint'(1) <<< (SAMPLE_BITS - 1));

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] new_temp;
    logic                          frame_end;
  } cell_result_t;

  logic                          clk;
  logic                          rst_n        = 1'b0;
  logic                          in_push      = 1'b0;
  logic signed [SAMPLE_BITS-1:0] in_old_temp  = '0;
  logic                          in_full;
  logic                          out_pop      = 1'b0;
  logic                          out_empty;
  logic signed [SAMPLE_BITS-1:0] out_new_temp;
  logic                          out_frame_end;
  logic                          cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_addr     = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata    = '0;

  heat_stencil_five_point #(
    .MAX_COLS   (MAX_COLS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_old_temp  (in_old_temp),
    .in_full      (in_full),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_new_temp (out_new_temp),
    .out_frame_end(out_frame_end),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  // Samples waiting to be pushed, and stencil results not yet popped
  logic signed [SAMPLE_BITS-1:0] pending_samples[$];
  cell_result_t                  expected_cells[$];

  // Pacing, percent of cycles in which each side holds back
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // Predictor state: registers as last written, raster position, line stores, window
  hsfp_cfg_t                     grid_cfg = '{COLS_RST, ROWS_RST, RATIO_RST};
  int unsigned                   col_pos  = 0;
  int unsigned                   row_pos  = 0;
  logic signed [SAMPLE_BITS-1:0] upper_line  [MAX_COLS+2] = '{default: '0};
  logic signed [SAMPLE_BITS-1:0] middle_line [MAX_COLS+2] = '{default: '0};
  logic signed [SAMPLE_BITS-1:0] win_centre = '0;  // middle row, previous column
  logic signed [SAMPLE_BITS-1:0] win_west   = '0;  // middle row, two columns back
  logic signed [SAMPLE_BITS-1:0] win_north  = '0;  // upper row, previous column
  logic signed [SAMPLE_BITS-1:0] win_south  = '0;  // incoming row, previous column
  cell_result_t                  head_cell;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Out-of-range widths are clamped by the block: 0 acts as 1, above MAX_COLS as MAX_COLS
  function automatic int unsigned grid_width();
    int unsigned cols;
    cols = grid_cfg.interior_cols;
    if (cols == 0) cols = 1;
    if (cols > MAX_COLS) cols = MAX_COLS;
    return cols + 2;
  endfunction

  function automatic int unsigned grid_height();
    int unsigned rows;
    rows = grid_cfg.interior_rows;
    if (rows == 0) rows = 1;
    return rows + 2;
  endfunction

  // Advance the predictor by one accepted sample; queues a result when the sample
  // is the south-east neighbour of an interior cell.
  task automatic predict_cell(input logic signed [SAMPLE_BITS-1:0] sample);
    int unsigned                   pw;
    int unsigned                   ph;
    logic signed [SAMPLE_BITS-1:0] mid_word;
    logic signed [SAMPLE_BITS-1:0] up_word;
    longint                        lap;
    longint                        prod;
    longint                        upd;
    cell_result_t                  res;
    pw = grid_width();
    ph = grid_height();
    if (col_pos >= pw) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= ph) row_pos = 0;
    mid_word = (row_pos >= 1) ? middle_line[col_pos] : '0;
    up_word  = (row_pos >= 2) ? upper_line[col_pos] : '0;
    if (row_pos >= 2 && col_pos >= 2) begin
      // mid_word is the east neighbour of the centre one column back
      lap  = longint'(win_north) + longint'(win_south) + longint'(mid_word)
           + longint'(win_west) - STENCIL_POINTS * longint'(win_centre);
      prod = longint'(grid_cfg.diffusion_ratio) * lap;
      // arithmetic shift floors, negative products included
      upd  = longint'(win_centre) + (prod >>> RATIO_FRAC);
      if (upd > TEMP_MAX) upd = TEMP_MAX;
      if (upd < TEMP_MIN) upd = TEMP_MIN;
      res.new_temp  = upd[SAMPLE_BITS-1:0];
      res.frame_end = (col_pos == pw - 1) && (row_pos == ph - 1);
      expected_cells.push_back(res);
    end
    win_west   = win_centre;
    win_centre = mid_word;
    win_north  = up_word;
    win_south  = sample;
    if (row_pos >= 1) upper_line[col_pos] = mid_word;
    middle_line[col_pos] = sample;
    col_pos++;
    if (col_pos >= pw) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= ph) row_pos = 0;
    end
  endtask

  task automatic note_mismatch(input string what, input logic [SAMPLE_BITS-1:0] want,
                               input logic [SAMPLE_BITS-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  // Driver: retires the accepted transaction into the predictor, then offers the next
  // sample unless this cycle is an idle one.
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) predict_cell(pending_samples.pop_front());
    if (rst_n && pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_push     <= 1'b1;
      in_old_temp <= pending_samples[0];
    end else begin
      in_push <= 1'b0;
    end
  end

  // Monitor: every popped result is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_cells.size() == 0) begin
        note_mismatch("unrequested new_temp", 'x, out_new_temp);
      end else begin
        head_cell = expected_cells.pop_front();
        if (out_new_temp !== head_cell.new_temp)
          note_mismatch("new_temp", head_cell.new_temp, out_new_temp);
        if (out_frame_end !== head_cell.frame_end)
          note_mismatch("frame_end", head_cell.frame_end, out_frame_end);
      end
    end
    out_pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a long run of cycles without any transaction means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Wait until every sample is in and every result out, then let the trailing halo
  // samples (which give no result) drain through the pipeline.
  task automatic settle();
    while (pending_samples.size() != 0 || expected_cells.size() != 0 || in_push)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers are only touched between frames, so the predictor takes them at once
  task automatic write_grid_cfg(input logic [CFG_DATA_W-1:0] cols_w,
                                input logic [CFG_DATA_W-1:0] rows_w,
                                input logic [CFG_DATA_W-1:0] ratio_w);
    settle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= IDX_INTERIOR_COLS;
    cfg_wdata <= cols_w;
    @(posedge clk);
    cfg_addr  <= IDX_INTERIOR_ROWS;
    cfg_wdata <= rows_w;
    @(posedge clk);
    cfg_addr  <= IDX_DIFFUSION_RATIO;
    cfg_wdata <= ratio_w;
    @(posedge clk);
    cfg_we <= 1'b0;
    grid_cfg.interior_cols   = cols_w[CFG_COLS_W-1:0];
    grid_cfg.interior_rows   = rows_w[CFG_ROWS_W-1:0];
    grid_cfg.diffusion_ratio = ratio_w[CFG_RATIO_W-1:0];
    @(negedge clk);
  endtask

  // Halo cells carry one value, interior cells another
  task automatic enqueue_uniform_frame(input logic signed [SAMPLE_BITS-1:0] halo,
                                       input logic signed [SAMPLE_BITS-1:0] inner);
    int unsigned pw;
    int unsigned ph;
    pw = grid_width();
    ph = grid_height();
    for (int unsigned r = 0; r < ph; r++)
      for (int unsigned c = 0; c < pw; c++)
        pending_samples.push_back((r >= 1 && r <= ph - 2 && c >= 1 && c <= pw - 2) ?
                                  inner : halo);
  endtask

  // Mostly a smooth field around a per-frame level, with raw noise and extremes mixed in
  task automatic enqueue_frame();
    int unsigned                   pw;
    int unsigned                   ph;
    int unsigned                   pick;
    logic signed [SAMPLE_BITS-1:0] level;
    logic signed [SAMPLE_BITS-1:0] temp;
    pw    = grid_width();
    ph    = grid_height();
    level = $signed($urandom) >>> 4;
    for (int unsigned n = 0; n < pw * ph; n++) begin
      pick = $urandom_range(99);
      if (pick < 50)
        temp = level + $signed($urandom_range(2047)) - 1024;
      else if (pick < 75)
        temp = $urandom;
      else
        case ($urandom_range(4))
          0:       temp = TEMP_MIN[SAMPLE_BITS-1:0];
          1:       temp = TEMP_MAX[SAMPLE_BITS-1:0];
          2:       temp = '0;
          3:       temp = -1;
          default: temp = 1;
        endcase
      pending_samples.push_back(temp);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] cols_w;
    logic [CFG_DATA_W-1:0] rows_w;
    logic [CFG_DATA_W-1:0] ratio_w;
    int unsigned           frames;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero width and height registers act as a single interior cell.
    // Maximum ratio with opposite extremes saturates low, then high; a centre of one
    // in a cold halo checks that the scaled Laplacian is floored, not truncated.
    write_grid_cfg('0, '0, 16'hFFFF);
    enqueue_uniform_frame(TEMP_MIN[SAMPLE_BITS-1:0], TEMP_MAX[SAMPLE_BITS-1:0]);
    enqueue_uniform_frame(TEMP_MAX[SAMPLE_BITS-1:0], TEMP_MIN[SAMPLE_BITS-1:0]);
    enqueue_uniform_frame('0, 1);

    // Register extremes, no idling. Bits above the column field are dropped (two
    // columns); zero ratio passes the centre straight through.
    write_grid_cfg(16'hF802, 16'd1, '0);
    enqueue_frame();
    // Tall grid, kept one column wide so the run stays short
    write_grid_cfg(16'd1, 16'd20, CFG_DATA_W'($urandom_range(65535)));
    enqueue_frame();

    // Random grids under each pacing regime; frames follow each other back to back
    for (int mode = 0; mode < 4; mode++) begin
      for (int k = 0; k < 3; k++) begin
        if (mode == 3 && k == 0) begin
          cols_w  = 16'd20;
          rows_w  = 16'd2;
          ratio_w = 16'hFFFF;
        end else begin
          cols_w = ($urandom_range(9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 8));
          rows_w = ($urandom_range(9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 5));
          case ($urandom_range(3))
            0:       ratio_w = '0;
            1:       ratio_w = 16'hFFFF;
            default: ratio_w = CFG_DATA_W'($urandom_range(65535));
          endcase
        end
        write_grid_cfg(cols_w, rows_w, ratio_w);
        case (mode)
          0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
          end
          1: begin
            send_idle_pct  = 84;
            recv_stall_pct = 0;
          end
          2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 84;
          end
          default: begin
            send_idle_pct  = 30;
            recv_stall_pct = 30;
          end
        endcase
        frames = $urandom_range(1, 2);
        repeat (frames) enqueue_frame();
      end
    end

    settle();
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
